/* src/bop_pkg.sv */
// Shared types and constants for the buffer ownership pool.
package bop_pkg;

    // Fixed field widths
    localparam int SLOT_IDX_W = 5;
    localparam int CMD_W      = 2;
    localparam int SSTATE_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;

    // Pool sizing
    localparam int MAX_SLOTS_DEFAULT = 32;
    localparam int SLOT_COUNT_RESET  = 4;
    localparam int SLOT_COUNT_MIN    = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ACQUIRE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRANSITION = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RECLAIM    = 2'd3;

    // Slot ownership codes
    localparam logic [SSTATE_W-1:0] SLOT_FREE   = 2'd0;
    localparam logic [SSTATE_W-1:0] SLOT_DEQ    = 2'd1;
    localparam logic [SSTATE_W-1:0] SLOT_QUEUED = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CORRUPT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd3;

    // Command sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RING,
        FSM_EXEC
    } fsm_state_t;

    // Request word
    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [SSTATE_W-1:0]   from_state;
        logic [SSTATE_W-1:0]   to_state;
    } req_t;

    // Response word
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] granted_index;
        logic                  any_dequeued;
        logic [COUNT_W-1:0]    free_count;
    } rsp_t;

endpackage

/* src/buffer_ownership_pool.sv */
// Buffer ownership pool: slot state memory, free index ring and command sequencer.
//
// Tracks a set of buffer slots, each free, dequeued (leased) or queued.
// Request channel (req_valid/req_ready/req) carries one command word:
// acquire, transition, release or reclaim-all. Response channel
// (rsp_valid/rsp_ready/rsp) returns exactly one word per command with the
// status, the granted slot, the lease flag and the free ring fill.
// Configuration: cfg_wr_en/cfg_wr_data sets the slot count (saturated to
// 2..MAX_SLOTS) and re-grants the pool; write it only while idle.
// The response is registered in the EXEC state after the command is
// accepted (ring head read at the accepting edge, slot state read in the
// RING state, read-modify-write and response register in EXEC).
// Each command makes two dependent reads (free ring head, then slot
// state) before the write-back; a new command is accepted only in IDLE,
// after the last one has written back, also while a response still waits.
// If the receiver stalls, the finished command holds in the write-back
// step until the response register drains; no state changes meanwhile.
// Reset: all slots free, ring holds indices 0..3, slot count 4. Pool
// refill (reset, reclaim, config) is instant through per-entry valid bits.
module buffer_ownership_pool #(
    parameter int MAX_SLOTS = bop_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  bop_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output bop_pkg::rsp_t                rsp,
    input  logic                         cfg_wr_en,
    input  logic [bop_pkg::COUNT_W-1:0]  cfg_wr_data
);
    import bop_pkg::*;

    localparam int PTR_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = CNT_W + COUNT_W;
    localparam int SC_INIT = (SLOT_COUNT_RESET > MAX_SLOTS) ? MAX_SLOTS : SLOT_COUNT_RESET;

    // Sequencer
    fsm_state_t state_reg, state_next;
    logic       ring_rd_en, slot_rd_en, exec_go;

    // Memories and their read registers
    logic [SLOT_IDX_W-1:0] ring_mem [MAX_SLOTS];
    logic [SSTATE_W-1:0]   slot_mem [MAX_SLOTS];
    logic [SLOT_IDX_W-1:0] ring_rd_reg;
    logic [SSTATE_W-1:0]   slot_rd_reg;

    // Valid bits: an invalid entry reads as its refill value
    logic [MAX_SLOTS-1:0]  ring_vld_reg, slot_vld_reg;

    // Pool registers
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [CNT_W-1:0]      leased_reg, leased_next;
    logic [CNT_W-1:0]      slot_count_reg, cfg_count;

    // Command context
    req_t                  req_reg;
    logic [SLOT_IDX_W-1:0] g_reg, g_next;
    logic [PTR_W-1:0]      slot_addr_reg, slot_addr_next;

    // Execute results
    logic                  slot_we, ring_we, reclaim;
    logic [SSTATE_W-1:0]   slot_wdata;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] granted;
    logic [SSTATE_W-1:0]   cur_state;
    logic                  idx_ok, g_ok, trans_ok, rel_ok, ring_full;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      tail;
    logic [CMP_W-1:0]      cfg_ext;

    // Response register
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg, rsp_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: if (req_valid) state_next = FSM_RING;
            FSM_RING: state_next = FSM_EXEC;
            FSM_EXEC: if (exec_go) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_ready  = 1'b0;
        ring_rd_en = 1'b0;
        slot_rd_en = 1'b0;
        exec_go    = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                req_ready  = 1'b1;
                ring_rd_en = req_valid;
            end
            FSM_RING: slot_rd_en = 1'b1;
            FSM_EXEC: exec_go = !rsp_valid_reg || rsp_ready;
            default:  req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FSM_IDLE;
        else
            state_reg <= state_next;
    end

    // Ring head entry, then slot address for the state read
    always_comb
    begin
        g_next = ring_vld_reg[head_reg] ? ring_rd_reg : SLOT_IDX_W'(head_reg);
        if (req_reg.cmd == CMD_ACQUIRE)
            slot_addr_next = PTR_W'(g_next);
        else
            slot_addr_next = PTR_W'(req_reg.slot_index);
    end

    // Command context capture
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
        if (slot_rd_en)
        begin
            g_reg         <= g_next;
            slot_addr_reg <= slot_addr_next;
        end
    end

    // Free ring memory
    always_ff @(posedge clk)
    begin
        if (exec_go && ring_we)
            ring_mem[tail] <= req_reg.slot_index;
        if (ring_rd_en)
            ring_rd_reg <= ring_mem[head_reg];
    end

    // Slot state memory
    always_ff @(posedge clk)
    begin
        if (exec_go && slot_we)
            slot_mem[slot_addr_reg] <= slot_wdata;
        if (slot_rd_en)
            slot_rd_reg <= slot_mem[slot_addr_next];
    end

    // Ring tail and range checks
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
        if (tail_sum >= SUM_W'(MAX_SLOTS))
            tail_sum = tail_sum - SUM_W'(MAX_SLOTS);
        tail      = PTR_W'(tail_sum);
        ring_full = fill_reg >= CNT_W'(MAX_SLOTS);
        cur_state = slot_vld_reg[slot_addr_reg] ? slot_rd_reg : SLOT_FREE;
        idx_ok    = CMP_W'(req_reg.slot_index) < CMP_W'(slot_count_reg);
        g_ok      = CMP_W'(g_reg) < CMP_W'(slot_count_reg);
        trans_ok  = idx_ok && (req_reg.from_state <= SLOT_QUEUED)
                    && (req_reg.to_state <= SLOT_QUEUED)
                    && (cur_state == req_reg.from_state)
                    && !((req_reg.to_state == SLOT_FREE) && ring_full);
        rel_ok    = idx_ok && (cur_state == SLOT_DEQ) && !ring_full;
    end

    // Command execution
    always_comb
    begin
        status      = STATUS_REFUSED;
        granted     = '0;
        slot_we     = 1'b0;
        slot_wdata  = SLOT_FREE;
        ring_we     = 1'b0;
        reclaim     = 1'b0;
        head_next   = head_reg;
        fill_next   = fill_reg;
        leased_next = leased_reg;
        case (req_reg.cmd)
            CMD_ACQUIRE:
            begin
                if (fill_reg != '0)
                begin
                    head_next = (head_reg == PTR_W'(MAX_SLOTS - 1)) ? '0 : head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                    if (!g_ok || cur_state != SLOT_FREE)
                        status = STATUS_CORRUPT;
                    else
                    begin
                        slot_we     = 1'b1;
                        slot_wdata  = SLOT_DEQ;
                        leased_next = leased_reg + 1'b1;
                        granted     = g_reg;
                        status      = STATUS_DONE;
                    end
                end
            end
            CMD_TRANSITION:
            begin
                if (trans_ok)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = req_reg.to_state;
                    if (req_reg.from_state == SLOT_DEQ && req_reg.to_state != SLOT_DEQ)
                        leased_next = leased_reg - 1'b1;
                    if (req_reg.to_state == SLOT_DEQ && req_reg.from_state != SLOT_DEQ)
                        leased_next = leased_reg + 1'b1;
                    if (req_reg.to_state == SLOT_FREE)
                    begin
                        ring_we   = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    status = STATUS_DONE;
                end
            end
            CMD_RELEASE:
            begin
                if (rel_ok)
                begin
                    slot_we     = 1'b1;
                    slot_wdata  = SLOT_FREE;
                    leased_next = leased_reg - 1'b1;
                    ring_we     = 1'b1;
                    fill_next   = fill_reg + 1'b1;
                    status      = STATUS_DONE;
                end
            end
            CMD_RECLAIM:
            begin
                if (leased_reg != '0)
                    status = STATUS_BLOCKED;
                else
                begin
                    reclaim   = 1'b1;
                    head_next = '0;
                    fill_next = slot_count_reg;
                    status    = STATUS_DONE;
                end
            end
            default: status = STATUS_REFUSED;
        endcase
    end

    // Slot count write with saturation
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_wr_data);
        if (cfg_ext < CMP_W'(SLOT_COUNT_MIN))
            cfg_count = CNT_W'(SLOT_COUNT_MIN);
        else if (cfg_ext > CMP_W'(MAX_SLOTS))
            cfg_count = CNT_W'(MAX_SLOTS);
        else
            cfg_count = CNT_W'(cfg_ext);
    end

    // Pool registers and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= CNT_W'(SC_INIT);
            head_reg       <= '0;
            fill_reg       <= CNT_W'(SC_INIT);
            leased_reg     <= '0;
            ring_vld_reg   <= '0;
            slot_vld_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            slot_count_reg <= cfg_count;
            head_reg       <= '0;
            fill_reg       <= cfg_count;
            leased_reg     <= '0;
            ring_vld_reg   <= '0;
            slot_vld_reg   <= '0;
        end
        else if (exec_go)
        begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            leased_reg <= leased_next;
            if (reclaim)
            begin
                ring_vld_reg <= '0;
                slot_vld_reg <= '0;
            end
            if (slot_we)
                slot_vld_reg[slot_addr_reg] <= 1'b1;
            if (ring_we)
                ring_vld_reg[tail] <= 1'b1;
        end
    end

    // Response word
    always_comb
    begin
        rsp_next.status        = status;
        rsp_next.granted_index = granted;
        rsp_next.any_dequeued  = leased_next != '0;
        rsp_next.free_count    = COUNT_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (exec_go)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // Ring never holds more than MAX_SLOTS entries
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_SLOTS))
        else $error("free ring fill above capacity");

    // Leases never exceed the slots in use
    assert property (@(posedge clk) disable iff (!rst_n)
        leased_reg <= slot_count_reg)
        else $error("lease count above slot count");

    // A slot count write re-grants the whole pool
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (fill_reg == slot_count_reg) && (leased_reg == '0) && (head_reg == '0))
        else $error("pool not refilled after slot count write");

    // Responses come only out of the write-back step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == FSM_EXEC))
        else $error("response raised outside write-back");
`endif

endmodule
